/* src/dtf_pkg.sv */
// Shared types, constants and the power-of-ten table for the decimal text parser.
package dtf_pkg;

    // Fixed storage widths of the parse state
    localparam int INT_W   = 31;
    localparam int FRAC_W  = 30;
    localparam int CNT_W   = 4;
    localparam int VALUE_W = 48;
    // Magnitude width before clamping: widest integer part, widest fraction, carry
    localparam int MAG_W   = INT_W + 24 + 2;

    // Character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;

    // Clamp limits of the 48-bit signed result
    localparam logic [MAG_W-1:0] POS_LIMIT = MAG_W'((64'd1 << (VALUE_W - 1)) - 64'd1);
    localparam logic [MAG_W-1:0] NEG_LIMIT = MAG_W'(64'd1 << (VALUE_W - 1));

    // Input request
    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } in_item_t;

    // Result
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      bad_char;
        logic                      saturated;
    } out_item_t;

    // One finished number, handed from parser to scaler
    typedef struct packed {
        logic [INT_W-1:0]  int_accum;
        logic [FRAC_W-1:0] frac_accum;
        logic [CNT_W-1:0]  frac_digit_count;
        logic              negative;
        logic              error_seen;
        logic              overflow_seen;
    } job_t;

    // Scaler sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SUM,
        BK_OUT
    } back_state_t;

    // 10^k, saturating at 10^9
    function automatic logic [FRAC_W-1:0] pow10(input logic [CNT_W-1:0] k);
        logic [FRAC_W-1:0] p;
        unique case (k)
            4'd0:    p = 30'd1;
            4'd1:    p = 30'd10;
            4'd2:    p = 30'd100;
            4'd3:    p = 30'd1000;
            4'd4:    p = 30'd10000;
            4'd5:    p = 30'd100000;
            4'd6:    p = 30'd1000000;
            4'd7:    p = 30'd10000000;
            4'd8:    p = 30'd100000000;
            default: p = 30'd1000000000;
        endcase
        return p;
    endfunction

endpackage

/* src/dtf_front.sv */
// Character parser: accumulates integer and fraction digits, emits one job per number.
module dtf_front
    import dtf_pkg::*;
#(
    parameter int MAX_FRAC_DIGITS = 9,
    parameter int INT_BITS        = 31
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     q_full,
    output logic     q_push,
    output job_t     q_job
);

    localparam logic [INT_W+4:0] INT_LIMIT = (INT_W+5)'((64'd1 << INT_BITS) - 64'd1);

    logic [INT_W-1:0]  int_accum_reg, int_accum_next;
    logic [FRAC_W-1:0] frac_accum_reg, frac_accum_next;
    logic [CNT_W-1:0]  frac_cnt_reg, frac_cnt_next;
    logic negative_reg, negative_next;
    logic in_frac_reg, in_frac_next;
    logic term_reg, term_next;
    logic err_reg, err_next;
    logic ovf_reg, ovf_next;
    logic first_reg;

    logic             accept;
    logic             is_digit;
    logic [3:0]       digit;
    logic [INT_W+4:0] int_x10;
    logic [FRAC_W+3:0] frac_x10;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && s_item.last_char;

    assign is_digit = (s_item.char_code >= CH_ZERO) && (s_item.char_code <= CH_NINE);
    assign digit    = 4'(s_item.char_code - CH_ZERO);
    // times ten as shift-add
    assign int_x10  = ((INT_W+5)'(int_accum_reg) << 3) + ((INT_W+5)'(int_accum_reg) << 1)
                    + (INT_W+5)'(digit);
    assign frac_x10 = ((FRAC_W+4)'(frac_accum_reg) << 3) + ((FRAC_W+4)'(frac_accum_reg) << 1)
                    + (FRAC_W+4)'(digit);

    // Effect of one character on the parse state
    always_comb begin
        int_accum_next  = int_accum_reg;
        frac_accum_next = frac_accum_reg;
        frac_cnt_next   = frac_cnt_reg;
        negative_next   = negative_reg;
        in_frac_next    = in_frac_reg;
        term_next       = term_reg;
        err_next        = err_reg;
        ovf_next        = ovf_reg;
        if (!term_reg) begin
            priority if (first_reg && (s_item.char_code == CH_PLUS ||
                                       s_item.char_code == CH_MINUS)) begin
                negative_next = (s_item.char_code == CH_MINUS);
            end else if (is_digit) begin
                if (in_frac_reg) begin
                    if (frac_cnt_reg < CNT_W'(MAX_FRAC_DIGITS)) begin
                        frac_accum_next = frac_x10[FRAC_W-1:0];
                        frac_cnt_next   = frac_cnt_reg + 1'b1;
                    end
                end else if (int_x10 > INT_LIMIT) begin
                    int_accum_next = INT_LIMIT[INT_W-1:0];
                    ovf_next       = 1'b1;
                end else begin
                    int_accum_next = int_x10[INT_W-1:0];
                end
            end else if (s_item.char_code == CH_POINT) begin
                if (in_frac_reg) begin
                    term_next = 1'b1;
                end else begin
                    in_frac_next = 1'b1;
                end
            end else begin
                err_next = 1'b1;
            end
        end
    end

    // Finished number goes to the queue
    always_comb begin
        q_job.int_accum        = int_accum_next;
        q_job.frac_accum       = frac_accum_next;
        q_job.frac_digit_count = frac_cnt_next;
        q_job.negative         = negative_next;
        q_job.error_seen       = err_next;
        q_job.overflow_seen    = ovf_next;
    end

    // Parse state; clears after the last character
    always_ff @(posedge aclk) begin
        if (!aresetn || q_push) begin
            int_accum_reg  <= '0;
            frac_accum_reg <= '0;
            frac_cnt_reg   <= '0;
            negative_reg   <= 1'b0;
            in_frac_reg    <= 1'b0;
            term_reg       <= 1'b0;
            err_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
            first_reg      <= 1'b1;
        end else if (accept) begin
            int_accum_reg  <= int_accum_next;
            frac_accum_reg <= frac_accum_next;
            frac_cnt_reg   <= frac_cnt_next;
            negative_reg   <= negative_next;
            in_frac_reg    <= in_frac_next;
            term_reg       <= term_next;
            err_reg        <= err_next;
            ovf_reg        <= ovf_next;
            first_reg      <= 1'b0;
        end
    end

endmodule

/* src/dtf_queue.sv */
// Two-entry job queue between parser and scaler.
module dtf_queue
    import dtf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    output logic empty,
    input  logic pop,
    output job_t head_job
);

    job_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_job = slot_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

/* src/dtf_back.sv */
// Scaler: divides the fraction by its power of ten, forms and clamps the fixed-point value.
module dtf_back
    import dtf_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      q_empty,
    output logic      q_pop,
    input  job_t      q_job,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    localparam int RW = FRAC_BITS + 32;
    localparam int QW = FRAC_BITS + 1;
    localparam int KW = $clog2(FRAC_BITS + 1);

    back_state_t state_reg, state_next;

    job_t            job_reg;
    logic [RW-1:0]   rem_reg;
    logic [RW-1:0]   dsh_reg;
    logic [QW-1:0]   q_reg;
    logic [KW-1:0]   cnt_reg;
    logic [MAG_W-1:0] mag_reg;
    logic            m_valid_reg;
    out_item_t       m_item_reg;

    logic            start;
    logic            load_out;
    logic            ge;
    logic [FRAC_W-1:0] div;
    logic [MAG_W-1:0]  mag_clamped;
    logic              sat;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;
    assign div     = pow10(q_job.frac_digit_count);
    assign ge      = (rem_reg >= dsh_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: if (!q_empty) state_next = BK_DIV;
            BK_DIV:  if (cnt_reg == '0) state_next = BK_SUM;
            BK_SUM:  state_next = BK_OUT;
            BK_OUT:  if (!m_valid_reg || m_ready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        start    = 1'b0;
        load_out = 1'b0;
        unique case (state_reg)
            BK_IDLE: start = !q_empty;
            BK_OUT:  load_out = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    assign q_pop = start;

    // Clamp and sign
    always_comb begin
        mag_clamped = mag_reg;
        sat         = job_reg.overflow_seen;
        if (job_reg.negative) begin
            if (mag_reg > NEG_LIMIT) begin
                mag_clamped = NEG_LIMIT;
                sat         = 1'b1;
            end
        end else if (mag_reg > POS_LIMIT) begin
            mag_clamped = POS_LIMIT;
            sat         = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Restoring divider: one quotient bit per cycle, round-half-up via the added divisor
    always_ff @(posedge aclk) begin
        if (start) begin
            job_reg <= q_job;
            rem_reg <= (RW'(q_job.frac_accum) << (FRAC_BITS + 1)) + RW'(div);
            dsh_reg <= RW'({div, 1'b0}) << FRAC_BITS;
            q_reg   <= '0;
            cnt_reg <= KW'(FRAC_BITS);
        end else if (state_reg == BK_DIV) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            dsh_reg <= dsh_reg >> 1;
            q_reg   <= {q_reg[QW-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (state_reg == BK_SUM) begin
            mag_reg <= (MAG_W'(job_reg.int_accum) << FRAC_BITS) + MAG_W'(q_reg);
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_item_reg.value     <= job_reg.negative ? -$signed(mag_clamped[VALUE_W-1:0])
                                                     : $signed(mag_clamped[VALUE_W-1:0]);
            m_item_reg.bad_char  <= job_reg.error_seen;
            m_item_reg.saturated <= sat;
        end
    end

endmodule

/* src/decimal_text_to_fixed_point_unit.sv */
// Top level: decimal text to signed fixed point, parser and scaler joined by a job queue.
//
//   channel | ports                      | carries
//   --------+----------------------------+------------------------------------------
//   input   | s_valid s_ready s_item     | one character request, last_char flag
//   result  | m_valid m_ready m_item     | value (48b, FRAC_BITS fraction), flags
//
// The parser takes one character per cycle while the queue is not full. The scaler works
// on one number at a time (bit-per-cycle divider, sum, clamp, output) before it takes the next.
// Two finished numbers can wait in the queue; s_ready drops only when it is full.
// Reset (aresetn, synchronous, active low) clears parse state, queue and output valid.
// A stalled result holds in the output register while parsing goes on.
module decimal_text_to_fixed_point_unit
    import dtf_pkg::*;
#(
    parameter int FRAC_BITS       = 16,
    parameter int MAX_FRAC_DIGITS = 9,
    parameter int INT_BITS        = 31
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic q_full;
    logic q_empty;
    logic q_push;
    logic q_pop;
    job_t push_job;
    job_t head_job;

    dtf_front #(
        .MAX_FRAC_DIGITS(MAX_FRAC_DIGITS),
        .INT_BITS       (INT_BITS)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_job   (push_job)
    );

    dtf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .empty    (q_empty),
        .pop      (q_pop),
        .head_job (head_job)
    );

    dtf_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_job   (head_job),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

/* tb/sv/tb.sv */
// Testbench for the decimal text to fixed point unit: random text, checked against a predictor.
module tb;
    import dtf_pkg::*;

    localparam int FRAC_BITS     = 16;
    localparam int MAX_FRAC_DIGS = 9;
    localparam logic [63:0] INT_MAX   = (64'd1 << 31) - 64'd1;
    localparam logic [63:0] POS_MAX   = (64'd1 << (VALUE_W - 1)) - 64'd1;
    localparam logic [63:0] NEG_MAX   = 64'd1 << (VALUE_W - 1);
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 60;

    typedef logic [7:0] text_t[$];

    // Predicts the parsed number of each text and checks the results in order
    class fixed_point_scoreboard;
        logic [31:0] int_acc;
        logic [29:0] frac_acc;
        logic [3:0]  frac_cnt;
        bit          neg, in_frac, stopped, bad_seen, clamp_seen, first;
        out_item_t   expected_values[$];
        int          errors;

        function new();
            errors = 0;
            clear_number();
        endfunction

        function void clear_number();
            int_acc    = '0;
            frac_acc   = '0;
            frac_cnt   = '0;
            neg        = 1'b0;
            in_frac    = 1'b0;
            stopped    = 1'b0;
            bad_seen   = 1'b0;
            clamp_seen = 1'b0;
            first      = 1'b1;
        endfunction

        function void absorb_char(logic [7:0] c);
            bit          was_first;
            logic [63:0] grown;
            was_first = first;
            first = 1'b0;
            if (stopped) return;
            // a sign counts only as the very first character
            if (was_first && (c == CH_PLUS || c == CH_MINUS)) begin
                neg = (c == CH_MINUS);
                return;
            end
            if (c >= CH_ZERO && c <= CH_NINE) begin
                if (in_frac) begin
                    if (frac_cnt < MAX_FRAC_DIGS) begin
                        frac_acc = frac_acc * 30'd10 + 30'(c - CH_ZERO);
                        frac_cnt = frac_cnt + 4'd1;
                    end
                end else begin
                    grown = 64'(int_acc) * 64'd10 + 64'(c - CH_ZERO);
                    if (grown > INT_MAX) begin
                        grown = INT_MAX;
                        clamp_seen = 1'b1;
                    end
                    int_acc = grown[31:0];
                end
            end else if (c == CH_POINT) begin
                if (in_frac) stopped = 1'b1;
                else in_frac = 1'b1;
            end else begin
                bad_seen = 1'b1;
            end
        endfunction

        // sign * (integer + rounded fraction), clamped to 48 bits signed
        function out_item_t finish_number();
            logic [63:0] scale, frac_fix, mag;
            bit          sat;
            out_item_t   r;
            scale = 64'd1;
            for (int i = 0; i < frac_cnt; i++) scale = scale * 64'd10;
            frac_fix = ((64'(frac_acc) << (FRAC_BITS + 1)) + scale) / (64'd2 * scale);
            mag = (64'(int_acc) << FRAC_BITS) + frac_fix;
            sat = clamp_seen;
            if (neg) begin
                if (mag > NEG_MAX) begin
                    mag = NEG_MAX;
                    sat = 1'b1;
                end
                r.value = VALUE_W'(64'd0 - mag);
            end else begin
                if (mag > POS_MAX) begin
                    mag = POS_MAX;
                    sat = 1'b1;
                end
                r.value = VALUE_W'(mag);
            end
            r.bad_char  = bad_seen;
            r.saturated = sat;
            clear_number();
            return r;
        endfunction

        function void note_request(in_item_t it);
            absorb_char(it.char_code);
            if (it.last_char) expected_values.push_back(finish_number());
        endfunction

        function int pending();
            return expected_values.size();
        endfunction

        task report(string msg);
            $display("%0t ERROR %s", $time, msg);
            errors++;
        endtask

        task check_result(out_item_t got);
            out_item_t exp_item;
            if (expected_values.size() == 0) begin
                report($sformatf("unexpected result value %0d", got.value));
                return;
            end
            exp_item = expected_values.pop_front();
            if (got.value !== exp_item.value)
                report($sformatf("value %0d, predicted %0d", got.value, exp_item.value));
            if (got.bad_char !== exp_item.bad_char)
                report($sformatf("bad_char %b, predicted %b", got.bad_char, exp_item.bad_char));
            if (got.saturated !== exp_item.saturated)
                report($sformatf("saturated %b, predicted %b",
                                 got.saturated, exp_item.saturated));
        endtask
    endclass

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    fixed_point_scoreboard book = new();
    bit gaps_on   = 1'b1;
    int hold_req  = 0;
    int sent_cnt  = 0;
    int stall_cnt = 0;

    decimal_text_to_fixed_point_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // One character request, with an optional gap before it
    task automatic send_char(input in_item_t it);
        int gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        do @(posedge aclk); while (!s_ready);
        book.note_request(it);
        sent_cnt++;
    endtask

    task automatic send_text(input text_t txt);
        in_item_t it;
        for (int i = 0; i < txt.size(); i++) begin
            it.char_code = txt[i];
            it.last_char = (i == txt.size() - 1);
            send_char(it);
        end
    endtask

    function automatic text_t text_bytes(string s);
        text_t q;
        for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
        return q;
    endfunction

    // Mostly well-formed numbers, some with stray characters, some pure noise
    task automatic send_number();
        text_t txt;
        int    style, n_int, n_frac, pick;
        bit    all_nines;
        style     = $urandom_range(0, 9);
        all_nines = ($urandom_range(0, 15) == 0);
        pick      = $urandom_range(0, 5);
        if (pick < 2) txt.push_back(CH_MINUS);
        else if (pick == 2) txt.push_back(CH_PLUS);
        n_int = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 13) : $urandom_range(0, 4);
        for (int i = 0; i < n_int; i++)
            txt.push_back(all_nines ? CH_NINE : 8'(CH_ZERO + $urandom_range(0, 9)));
        if ($urandom_range(0, 9) < 7) begin
            txt.push_back(CH_POINT);
            n_frac = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5);
            for (int i = 0; i < n_frac; i++)
                txt.push_back(all_nines ? CH_NINE : 8'(CH_ZERO + $urandom_range(0, 9)));
        end
        if (style == 9) begin
            txt.delete();
            repeat ($urandom_range(1, 6)) txt.push_back(8'($urandom_range(0, 255)));
        end else if (style >= 7) begin
            repeat ($urandom_range(1, 2)) begin
                pick = $urandom_range(0, 3);
                txt.insert($urandom_range(0, txt.size()),
                           pick == 0 ? CH_POINT : pick == 1 ? CH_MINUS :
                           pick == 2 ? CH_PLUS : 8'($urandom_range(0, 255)));
            end
        end
        if (txt.size() == 0) txt.push_back(8'($urandom_range(0, 255)));
        send_text(txt);
    endtask

    task automatic send_until(input int total);
        while (sent_cnt < total) send_number();
    endtask

    // Sender stays quiet until every predicted result has come back
    task automatic wait_for_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (book.pending() > 0) @(posedge aclk);
    endtask

    // Result side: random stalls, plus one long hold on request
    initial begin
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_req > 0) begin
                m_ready <= 1'b0;
                repeat (hold_req) @(posedge aclk);
                hold_req = 0;
            end else if (gaps_on) begin
                int gap;
                gap = $urandom_range(0, 4);
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            book.check_result(m_item);
        end
    end

    // Watchdog: too long without any handshake ends the run
    initial begin
        while (stall_cnt < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) stall_cnt = 0;
            else stall_cnt++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        text_t txt;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: sign only, bad and misplaced sign, second point, clamps
        send_text(text_bytes("+"));
        txt = {};
        txt.push_back(8'h00);
        txt.push_back(CH_MINUS);
        send_text(txt);
        txt = text_bytes("7.5.");
        txt.push_back(8'hFF);
        send_text(txt);
        send_text(text_bytes("9999999999.9999999999"));
        wait_for_results();

        // Random text with gaps on both sides
        gaps_on = 1'b1;
        send_until(600);

        // Receiver holds off while the sender keeps pushing
        gaps_on  = 1'b0;
        hold_req = HOLD_CYCLES;
        send_until(900);
        wait_for_results();

        // Full rate, then gaps again
        send_until(1300);
        gaps_on = 1'b1;
        send_until(1800);

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (book.pending() != 0)
            book.report($sformatf("%0d results never arrived", book.pending()));
        if (book.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
